// ----- rtl/core/pflr_pkg.sv -----
`default_nettype none

// Shared types and codes of the page framebuffer line rasteriser
package pflr_pkg;

    // Width of address and size arithmetic: page (5 bits) times width (9 bits)
    localparam int CALC_W = 14;

    // Request codes
    localparam logic [1:0] REQ_LINE    = 2'd0;
    localparam logic [1:0] REQ_CLR_PIX = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_CLR_BUF = 2'd3;

    // Configuration register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [7:0] width;
        logic [6:0] height;
    } t_cfg;

    // Classified command word: walk a from a_start up to a_end, minor axis b
    typedef struct packed {
        logic [1:0] op;
        logic       major_x;
        logic       step_neg;
        logic [7:0] a_start;
        logic [7:0] a_end;
        logic [7:0] b_start;
        logic [7:0] dmaj;
        logic [7:0] dmin;
        logic [9:0] addr;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/pflr_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module pflr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/pflr_fifo.sv -----
`default_nettype none

// Small first-word-fall-through queue
module pflr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_din,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pflr_front.sv -----
`default_nettype none

// Front end: takes request words, classifies lines by octant and queues commands
module pflr_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_hold,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_start_x,
    input  wire logic [7:0] i_start_y,
    input  wire logic [7:0] i_end_x,
    input  wire logic [7:0] i_end_y,
    input  wire logic [9:0] i_byte_addr,
    output logic            o_cmd_vld,
    input  wire logic       i_cmd_rdy,
    output pflr_pkg::t_cmd  o_cmd
);

    import pflr_pkg::*;

    t_cmd       cmd_in;
    logic       q_full;
    logic       q_empty;
    logic       x_rev;
    logic       y_rev;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] b_end;
    logic       low;

    // Absolute deltas and octant choice
    assign x_rev = (i_end_x < i_start_x);
    assign y_rev = (i_end_y < i_start_y);
    assign dx    = x_rev ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign dy    = y_rev ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
    assign low   = (dy < dx);

    // Orient the walk so the major axis counts upward
    always_comb begin
        cmd_in      = '0;
        b_end       = '0;
        cmd_in.op   = i_req_type;
        cmd_in.addr = i_byte_addr;
        if (low) begin
            cmd_in.major_x = 1'b1;
            cmd_in.a_start = x_rev ? i_end_x : i_start_x;
            cmd_in.a_end   = x_rev ? i_start_x : i_end_x;
            cmd_in.b_start = x_rev ? i_end_y : i_start_y;
            b_end          = x_rev ? i_start_y : i_end_y;
            cmd_in.dmaj    = dx;
            cmd_in.dmin    = dy;
        end else begin
            cmd_in.major_x = 1'b0;
            cmd_in.a_start = y_rev ? i_end_y : i_start_y;
            cmd_in.a_end   = y_rev ? i_start_y : i_end_y;
            cmd_in.b_start = y_rev ? i_end_x : i_start_x;
            b_end          = y_rev ? i_start_x : i_end_x;
            cmd_in.dmaj    = dy;
            cmd_in.dmin    = dx;
        end
        cmd_in.step_neg = (b_end < cmd_in.b_start);
        // clearing a pixel is a one-pixel walk
        if (i_req_type == REQ_CLR_PIX) begin
            cmd_in.major_x  = 1'b1;
            cmd_in.step_neg = 1'b0;
            cmd_in.a_start  = i_start_x;
            cmd_in.a_end    = i_start_x;
            cmd_in.b_start  = i_start_y;
            cmd_in.dmaj     = '0;
            cmd_in.dmin     = '0;
        end
    end

    // Command queue between front and back
    pflr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_din   (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_cmd_rdy),
        .o_empty (q_empty),
        .o_dout  (o_cmd)
    );

    assign o_full    = q_full || i_hold;
    assign o_cmd_vld = !q_empty;

endmodule

`default_nettype wire

// ----- rtl/core/pflr_back.sv -----
`default_nettype none

// Back end: walks lines, read-modify-writes framebuffer bytes, reads and clears
module pflr_back #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int DEPTH      = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pflr_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_vld,
    output logic               o_cmd_rdy,
    input  wire pflr_pkg::t_cmd i_cmd,
    output logic               o_init,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [7:0]         o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  wire logic [7:0]    i_ram_rdata,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_read_data,
    output logic               o_status
);

    import pflr_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DRAW  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    // Control registers
    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_bad, n_bad;
    logic              r_wb_vld, n_wb_vld;
    logic              r_last_vld, n_last_vld;
    // Walk registers
    logic              r_clr_pix, n_clr_pix;
    logic              r_major_x, n_major_x;
    logic              r_step_neg, n_step_neg;
    logic [7:0]        r_a, n_a;
    logic [7:0]        r_a_end, n_a_end;
    logic [7:0]        r_b, n_b;
    logic [7:0]        r_dmaj, n_dmaj;
    logic [7:0]        r_dmin, n_dmin;
    logic signed [11:0] r_d, n_d;
    // Write-back stage and forwarding
    logic [AW-1:0]     r_wb_addr, n_wb_addr;
    logic [7:0]        r_wb_mask, n_wb_mask;
    logic              r_wb_clr, n_wb_clr;
    logic [AW-1:0]     r_last_addr, n_last_addr;
    logic [7:0]        r_last_data, n_last_data;

    logic [8:0]        eff_w;
    logic [6:0]        eff_h;
    logic [7:0]        h_sum;
    logic [4:0]        pages;
    logic [CALC_W-1:0] used;
    logic [7:0]        px;
    logic [7:0]        py;
    logic              pix_ok;
    logic [CALC_W-1:0] pix_addr_full;
    logic              rd_ok;
    logic              cmd_take;
    logic              d_pos;
    logic [7:0]        wb_src;
    logic              rq_push;
    t_result           rq_data;
    logic              rq_full;
    t_result           rq_dout;

    // Active area from configuration
    assign eff_w = ({1'b0, i_cfg.width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, i_cfg.width};
    assign eff_h = ({2'b0, i_cfg.height} > 9'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : i_cfg.height;
    assign h_sum = {1'b0, eff_h} + 8'd7;
    assign pages = h_sum[7:3];
    assign used  = CALC_W'(eff_w) * CALC_W'(pages);

    // Current pixel and its byte address
    assign px            = r_major_x ? r_a : r_b;
    assign py            = r_major_x ? r_b : r_a;
    assign pix_ok        = ({1'b0, px} < eff_w) && (py < {1'b0, eff_h});
    assign pix_addr_full = CALC_W'(py[7:3]) * CALC_W'(eff_w) + CALC_W'(px);

    assign rd_ok     = (CALC_W'(i_cmd.addr) < used);
    assign cmd_take  = i_cmd_vld && (r_state == S_IDLE) && !rq_full;
    assign o_cmd_rdy = cmd_take;
    assign o_init    = (r_state == S_INIT);
    assign d_pos     = (r_d > 12'sd0);

    // Forward the byte written last cycle, the RAM still shows the old one
    assign wb_src = (r_last_vld && (r_last_addr == r_wb_addr)) ? r_last_data : i_ram_rdata;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bad       = r_bad;
        n_clr_pix   = r_clr_pix;
        n_major_x   = r_major_x;
        n_step_neg  = r_step_neg;
        n_a         = r_a;
        n_a_end     = r_a_end;
        n_b         = r_b;
        n_dmaj      = r_dmaj;
        n_dmin      = r_dmin;
        n_d         = r_d;
        n_wb_vld    = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_wb_mask   = r_wb_mask;
        n_wb_clr    = r_wb_clr;
        o_ram_raddr = pix_addr_full[AW-1:0];
        rq_push     = 1'b0;
        rq_data     = '0;

        // write-back stage of the pixel pipeline
        o_ram_we    = r_wb_vld;
        o_ram_waddr = r_wb_addr;
        o_ram_wdata = r_wb_clr ? (wb_src & ~r_wb_mask) : (wb_src | r_wb_mask);
        n_last_vld  = r_wb_vld;
        n_last_addr = r_wb_addr;
        n_last_data = o_ram_wdata;

        case (r_state)
            // sweep the whole store after reset
            S_INIT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cnt;
                o_ram_wdata = '0;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_IDLE: begin
                o_ram_raddr = AW'(i_cmd.addr);
                if (cmd_take) begin
                    n_bad      = 1'b0;
                    n_clr_pix  = (i_cmd.op == REQ_CLR_PIX);
                    n_major_x  = i_cmd.major_x;
                    n_step_neg = i_cmd.step_neg;
                    n_a        = i_cmd.a_start;
                    n_a_end    = i_cmd.a_end;
                    n_b        = i_cmd.b_start;
                    n_dmaj     = i_cmd.dmaj;
                    n_dmin     = i_cmd.dmin;
                    n_d        = $signed({3'b0, i_cmd.dmin, 1'b0})
                               - $signed({4'b0, i_cmd.dmaj});
                    n_cnt      = '0;
                    case (i_cmd.op)
                        REQ_LINE, REQ_CLR_PIX: begin
                            n_state = S_DRAW;
                        end
                        REQ_READ: begin
                            if (rd_ok) begin
                                n_state = S_READ;
                            end else begin
                                rq_push        = 1'b1;
                                rq_data.status = 1'b1;
                            end
                        end
                        REQ_CLR_BUF: begin
                            if (used == '0) begin
                                rq_push = 1'b1;
                            end else begin
                                n_state = S_CLEAR;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // one pixel per cycle, Bresenham step on the minor axis
            S_DRAW: begin
                if (pix_ok) begin
                    n_wb_vld  = 1'b1;
                    n_wb_addr = pix_addr_full[AW-1:0];
                    n_wb_mask = 8'd1 << py[2:0];
                    n_wb_clr  = r_clr_pix;
                end else begin
                    n_bad = 1'b1;
                end
                if (r_a == r_a_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_a = r_a + 8'd1;
                    if (d_pos) begin
                        n_b = r_step_neg ? (r_b - 8'd1) : (r_b + 8'd1);
                    end
                    n_d = r_d + $signed({3'b0, r_dmin, 1'b0})
                        - (d_pos ? $signed({3'b0, r_dmaj, 1'b0}) : 12'sd0);
                end
            end
            // last write goes out this cycle
            S_FLUSH: begin
                rq_push        = 1'b1;
                rq_data.status = r_bad;
                n_state        = S_IDLE;
            end
            S_READ: begin
                rq_push           = 1'b1;
                rq_data.read_data = i_ram_rdata;
                n_state           = S_IDLE;
            end
            // zero the used area
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cnt;
                o_ram_wdata = '0;
                if (CALC_W'(r_cnt) == used - CALC_W'(1)) begin
                    rq_push = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cnt      <= '0;
            r_bad      <= 1'b0;
            r_wb_vld   <= 1'b0;
            r_last_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_bad      <= n_bad;
            r_wb_vld   <= n_wb_vld;
            r_last_vld <= n_last_vld;
        end
    end

    // Walk and pipeline payload
    always_ff @(posedge i_clk) begin
        r_clr_pix   <= n_clr_pix;
        r_major_x   <= n_major_x;
        r_step_neg  <= n_step_neg;
        r_a         <= n_a;
        r_a_end     <= n_a_end;
        r_b         <= n_b;
        r_dmaj      <= n_dmaj;
        r_dmin      <= n_dmin;
        r_d         <= n_d;
        r_wb_addr   <= n_wb_addr;
        r_wb_mask   <= n_wb_mask;
        r_wb_clr    <= n_wb_clr;
        r_last_addr <= n_last_addr;
        r_last_data <= n_last_data;
    end

    // Result queue
    pflr_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_din   (rq_data),
        .o_full  (rq_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_dout  (rq_dout)
    );

    assign o_read_data = rq_dout.read_data;
    assign o_status    = rq_dout.status;

`ifndef NO_ASSERTIONS
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_push |-> !rq_full)
        else $error("result pushed into a full queue");
    a_wb_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> (r_state == S_DRAW || r_state == S_FLUSH))
        else $error("pixel write-back outside a line walk");
    a_flush_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> ($past(r_state) == S_DRAW))
        else $error("flush not preceded by the last walk step");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/page_framebuffer_line_rasterizer.sv -----
`default_nettype none

// Throughput: one pixel per cycle while a line is walked; the back end takes no new
//   command until the line's result is queued.
// Reset: synchronous, active low; width 128, height 64, then a clearing pass over all
//   MAX_WIDTH*ceil(MAX_HEIGHT/8) store bytes (1024), with full held high meanwhile.
module page_framebuffer_line_rasterizer #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_start_x,
    input  wire logic [7:0] i_start_y,
    input  wire logic [7:0] i_end_x,
    input  wire logic [7:0] i_end_y,
    input  wire logic [9:0] i_byte_addr,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_read_data,
    output logic            o_status
);

    import pflr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);
    localparam int AW    = $clog2(DEPTH);

    t_cfg          r_cfg;
    logic          init;
    logic          cmd_vld;
    logic          cmd_rdy;
    t_cmd          cmd;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 8'd128;
            r_cfg.height <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_cfg.height <= i_cfg_data[6:0];
                default:        r_cfg        <= r_cfg;
            endcase
        end
    end

    pflr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (init),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_byte_addr (i_byte_addr),
        .o_cmd_vld   (cmd_vld),
        .i_cmd_rdy   (cmd_rdy),
        .o_cmd       (cmd)
    );

    pflr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_vld   (cmd_vld),
        .o_cmd_rdy   (cmd_rdy),
        .i_cmd       (cmd),
        .o_init      (init),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

    // Framebuffer store
    pflr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- tb/page_framebuffer_line_rasterizer_tb.sv -----
`timescale 1ns / 1ps

module page_framebuffer_line_rasterizer_tb;
    import pflr_pkg::*;

    localparam int MAX_W        = 128;
    localparam int MAX_H        = 64;
    localparam int STORE_BYTES  = MAX_W * ((MAX_H + 7) / 8);
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int NUM_SETTINGS = 9;
    localparam int CHUNK_ITEMS  = 90;

    // One request word as the sender sees it
    typedef struct {
        logic [1:0] kind;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic [9:0] addr;
    } t_draw_req;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = 1'b0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       push        = 1'b0;
    logic [1:0] i_req_type  = 2'd0;
    logic [7:0] i_start_x   = 8'd0;
    logic [7:0] i_start_y   = 8'd0;
    logic [7:0] i_end_x     = 8'd0;
    logic [7:0] i_end_y     = 8'd0;
    logic [9:0] i_byte_addr = 10'd0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_read_data;
    logic       o_status;

    // Shadow framebuffer and display size
    logic [7:0] frame_mem [STORE_BYTES];
    logic [7:0] cfg_width  = 8'd128;
    logic [7:0] cfg_height = 8'd64;

    t_draw_req request_q [$];
    t_result   reply_q   [$];
    t_draw_req cur_req;

    int tx_idle_pct = 34;
    int rx_idle_pct = 34;
    int err_cnt     = 0;
    int reply_cnt   = 0;
    int kind_cnt [4];
    int cycle_cnt   = 0;

    page_framebuffer_line_rasterizer #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_byte_addr (i_byte_addr),
        .empty       (empty),
        .pop         (pop),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Clipped display size
    function automatic int eff_width();
        return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height > MAX_H) ? MAX_H : int'(cfg_height);
    endfunction

    function automatic int used_bytes();
        int n;
        n = eff_width() * ((eff_height() + 7) / 8);
        return (n > STORE_BYTES) ? STORE_BYTES : n;
    endfunction

    // Set or clear one pixel; 0 when it falls outside the display
    function automatic bit pixel_touch(int x, int y, bit set);
        int         a;
        logic [7:0] bitmask;
        if (x < 0 || y < 0 || x >= eff_width() || y >= eff_height())
            return 1'b0;
        a = x + (y / 8) * eff_width();
        if (a >= STORE_BYTES)
            return 1'b0;
        bitmask = 8'h01 << (y % 8);
        if (set)
            frame_mem[a] = frame_mem[a] | bitmask;
        else
            frame_mem[a] = frame_mem[a] & ~bitmask;
        return 1'b1;
    endfunction

    // Rasterise a line, endpoints included; 1 if any pixel was skipped
    function automatic bit line_draw(int x0, int y0, int x1, int y1);
        bit bad;
        int t, dx, dy, d, stp, a, b, adx, ady;
        bad = 1'b0;
        if (y0 == y1) begin
            if (x0 > x1) begin
                t = x0; x0 = x1; x1 = t;
            end
            for (a = x0; a <= x1; a++)
                bad |= !pixel_touch(a, y0, 1'b1);
            return bad;
        end
        if (x0 == x1) begin
            if (y0 > y1) begin
                t = y0; y0 = y1; y1 = t;
            end
            for (a = y0; a <= y1; a++)
                bad |= !pixel_touch(x0, a, 1'b1);
            return bad;
        end
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (ady < adx) begin
            // shallow: walk x upward
            if (x0 > x1) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dx  = x1 - x0;
            dy  = y1 - y0;
            stp = 1;
            if (dy < 0) begin
                stp = -1;
                dy  = -dy;
            end
            d = 2 * dy - dx;
            b = y0;
            for (a = x0; a <= x1; a++) begin
                bad |= !pixel_touch(a, b, 1'b1);
                if (d > 0) begin
                    b += stp;
                    d -= 2 * dx;
                end
                d += 2 * dy;
            end
        end else begin
            // steep (and exact diagonal): walk y upward
            if (y0 > y1) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dx  = x1 - x0;
            dy  = y1 - y0;
            stp = 1;
            if (dx < 0) begin
                stp = -1;
                dx  = -dx;
            end
            d = 2 * dx - dy;
            b = x0;
            for (a = y0; a <= y1; a++) begin
                bad |= !pixel_touch(b, a, 1'b1);
                if (d > 0) begin
                    b += stp;
                    d -= 2 * dy;
                end
                d += 2 * dx;
            end
        end
        return bad;
    endfunction

    // Apply one request to the shadow framebuffer, return the reply word
    function automatic t_result predict_reply(t_draw_req r);
        t_result res;
        res.read_data = 8'd0;
        res.status    = 1'b0;
        case (r.kind)
            REQ_LINE: begin
                res.status = line_draw(r.x0, r.y0, r.x1, r.y1);
            end
            REQ_CLR_PIX: begin
                res.status = !pixel_touch(r.x0, r.y0, 1'b0);
            end
            REQ_READ: begin
                if (int'(r.addr) < used_bytes())
                    res.read_data = frame_mem[r.addr];
                else
                    res.status = 1'b1;
            end
            default: begin
                for (int i = 0; i < used_bytes(); i++)
                    frame_mem[i] = 8'd0;
            end
        endcase
        return res;
    endfunction

    function automatic t_draw_req make_req(logic [1:0] kind, int x0, int y0, int x1, int y1,
                                           int addr);
        t_draw_req r;
        r.kind = kind;
        r.x0   = 8'(x0);
        r.y0   = 8'(y0);
        r.x1   = 8'(x1);
        r.y1   = 8'(y1);
        r.addr = 10'(addr);
        return r;
    endfunction

    // Random request, mostly aimed at the active area of the display
    function automatic t_draw_req random_request();
        t_draw_req r;
        int        pick, cx, cy, used;
        r.x0   = 8'($urandom);
        r.y0   = 8'($urandom);
        r.x1   = 8'($urandom);
        r.y1   = 8'($urandom);
        r.addr = 10'($urandom);
        pick = $urandom_range(99);
        if (pick < 45)
            r.kind = REQ_LINE;
        else if (pick < 60)
            r.kind = REQ_CLR_PIX;
        else if (pick < 97)
            r.kind = REQ_READ;
        else
            r.kind = REQ_CLR_BUF;
        cx = eff_width() + 2;
        cy = eff_height() + 2;
        if ($urandom_range(99) < 80) begin
            r.x0 = 8'($urandom_range(cx, 0));
            r.y0 = 8'($urandom_range(cy, 0));
            r.x1 = 8'($urandom_range(cx, 0));
            r.y1 = 8'($urandom_range(cy, 0));
        end
        used = used_bytes();
        if (used > 0 && $urandom_range(99) < 75)
            r.addr = 10'($urandom_range(used - 1, 0));
        return r;
    endfunction

    // Sender pauses until every reply has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || push || reply_q.size() != 0);
    endtask

    task automatic reg_write(logic idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_IDX_WIDTH)
            cfg_width = val;
        else
            cfg_height = val & 8'h7F;
    endtask

    // Request driver: predicts each word as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                reply_q.push_back(predict_reply(cur_req));
                kind_cnt[cur_req.kind]++;
            end
            if (!push || !full) begin
                if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_req = request_q.pop_front();
                    i_req_type  <= cur_req.kind;
                    i_start_x   <= cur_req.x0;
                    i_start_y   <= cur_req.y0;
                    i_end_x     <= cur_req.x1;
                    i_end_y     <= cur_req.y1;
                    i_byte_addr <= cur_req.addr;
                    push        <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: compares each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected reply: read_data %0d status %0d", o_read_data, o_status);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    reply_cnt++;
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %0d, got %0d", want.read_data, o_read_data);
                        err_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        err_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("page_framebuffer_line_rasterizer_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [7:0] set_w [NUM_SETTINGS];
        logic [7:0] set_h [NUM_SETTINGS];
        set_w = '{8'd255, 8'd1, 8'd37, 8'd0, 8'd90, 8'd64, 8'd129, 8'd8, 8'd128};
        set_h = '{8'd255, 8'd8, 8'd24, 8'd40, 8'd0, 8'd13, 8'd65, 8'd127, 8'd64};
        foreach (frame_mem[i])
            frame_mem[i] = 8'd0;
        foreach (kind_cnt[i])
            kind_cnt[i] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size of 128 x 64
        @(negedge i_clk);
        request_q.push_back(make_req(REQ_CLR_BUF, 0, 0, 0, 0, 0));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0));
        request_q.push_back(make_req(REQ_LINE, 0, 0, 127, 0, 0));
        request_q.push_back(make_req(REQ_LINE, 127, 63, 0, 63, 0));
        request_q.push_back(make_req(REQ_LINE, 5, 0, 5, 63, 0));
        request_q.push_back(make_req(REQ_LINE, 120, 63, 120, 0, 0));
        request_q.push_back(make_req(REQ_LINE, 64, 33, 64, 33, 0));
        request_q.push_back(make_req(REQ_LINE, 0, 10, 100, 40, 0));
        request_q.push_back(make_req(REQ_LINE, 100, 5, 3, 50, 0));
        request_q.push_back(make_req(REQ_LINE, 10, 0, 30, 63, 0));
        request_q.push_back(make_req(REQ_LINE, 60, 60, 90, 2, 0));
        request_q.push_back(make_req(REQ_LINE, 0, 0, 63, 63, 0));
        request_q.push_back(make_req(REQ_LINE, 120, 60, 255, 255, 0));
        request_q.push_back(make_req(REQ_LINE, 200, 255, 255, 200, 0));
        request_q.push_back(make_req(REQ_CLR_PIX, 5, 10, 0, 0, 0));
        request_q.push_back(make_req(REQ_CLR_PIX, 128, 0, 0, 0, 0));
        request_q.push_back(make_req(REQ_CLR_PIX, 0, 64, 0, 0, 0));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 133));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 1023));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 576));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 127));
        request_q.push_back(make_req(REQ_CLR_BUF, 0, 0, 0, 0, 0));
        request_q.push_back(make_req(REQ_READ, 0, 0, 0, 0, 127));
        wait_drained();

        // Random part, one phase per display size
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            reg_write(CFG_IDX_WIDTH, set_w[s]);
            reg_write(CFG_IDX_HEIGHT, set_h[s]);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);
            // last phase runs flat out on both sides
            tx_idle_pct = (s == NUM_SETTINGS - 1) ? 0 : 34;
            rx_idle_pct = tx_idle_pct;
            for (int c = 0; c < 2; c++) begin
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    request_q.push_back(random_request());
                wait_drained();
            end
        end

        repeat (40) @(posedge i_clk);
        $display("Covered %0d lines, %0d pixel clears, %0d byte reads, %0d buffer clears",
                 kind_cnt[REQ_LINE], kind_cnt[REQ_CLR_PIX], kind_cnt[REQ_READ],
                 kind_cnt[REQ_CLR_BUF]);
        $display("%0d replies checked over %0d display sizes, %0d mismatches",
                 reply_cnt, NUM_SETTINGS + 1, err_cnt);
        if (err_cnt == 0 && reply_q.size() == 0) begin
            $display("page_framebuffer_line_rasterizer_tb OK");
        end else begin
            $display("page_framebuffer_line_rasterizer_tb NOT OK");
        end
        $finish;
    end

endmodule
